/* design/text_stream_show_and_number_top_assert.svh */
// Assertion macros shared by the text stream show-and-number design.
// Each macro expects signals named clk and arst_n in the module that uses it.
`ifndef TEXT_STREAM_SHOW_AND_NUMBER_TOP_ASSERT_SVH
`define TEXT_STREAM_SHOW_AND_NUMBER_TOP_ASSERT_SVH

// Same-cycle implication, switched off while reset is asserted.
`define TSN_ASSERT_IMPLIES(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, switched off while reset is asserted.
`define TSN_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* design/tsn_pkg.sv */
// Package for the text stream show-and-number filter.
// Holds character codes, register indexes, the back-end phase type and the
// descriptor that travels from the front end to the back end. No dependencies.
package tsn_pkg;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 2;

	localparam logic [CFG_IDX_W-1:0] REG_NUMBER_MODE      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SQUEEZE_BLANK    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SHOW_ENDS        = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SHOW_TABS        = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SHOW_NONPRINTING = 3'd4;

	localparam logic [1:0] MODE_NONE     = 2'd0;
	localparam logic [1:0] MODE_ALL      = 2'd1;
	localparam logic [1:0] MODE_NONBLANK = 2'd2;

	localparam logic [7:0] CH_TAB      = 8'h09;
	localparam logic [7:0] CH_NL       = 8'h0A;
	localparam logic [7:0] CH_PRINT_LO = 8'h20;
	localparam logic [7:0] CH_SPACE    = 8'h20;
	localparam logic [7:0] CH_DOLLAR   = 8'h24;
	localparam logic [7:0] CH_DASH     = 8'h2D;
	localparam logic [7:0] CH_ZERO     = 8'h30;
	localparam logic [7:0] CH_QMARK    = 8'h3F;
	localparam logic [7:0] CH_I        = 8'h49;
	localparam logic [7:0] CH_M        = 8'h4D;
	localparam logic [7:0] CH_HAT      = 8'h5E;
	localparam logic [7:0] CH_DEL      = 8'h7F;
	localparam logic [7:0] CH_HIGH     = 8'h80;
	localparam logic [7:0] CTRL_OFFSET = 8'h40;

	localparam int QUEUE_DEPTH = 2;

	// Back-end output phases, in emission order.
	typedef enum logic [2:0] {
		PH_NUM  = 3'd0,
		PH_TAB  = 3'd1,
		PH_END  = 3'd2,
		PH_M    = 3'd3,
		PH_DASH = 3'd4,
		PH_HAT  = 3'd5,
		PH_CHAR = 3'd6,
		PH_IDLE = 3'd7
	} phase_t;

	// What the back end has to emit for one input byte, apart from the number.
	typedef struct packed {
		logic       num_en;
		logic       dollar;
		logic       m_dash;
		logic       hat;
		logic [7:0] ch;
	} ctrl_t;

endpackage

/* design/text_stream_show_and_number_top.sv */
// Channel  | dir | payload                                  | handshake
// s_       | in  | tdata: in_byte [7:0]; tuser: file_start  | s_tvalid / s_tready
// m_       | out | tdata: out_byte [7:0]; tlast: last_of_run| m_tvalid / m_tready
// cfg_     | in  | index [2:0], wdata [1:0]                 | cfg_we, no wait
//
// The front end takes one input beat a cycle while the two-entry descriptor
// queue has room. The back end emits one output beat a cycle while m_tready
// allows, and an input byte expands into 1 to NUMBER_DIGITS+5 output bytes;
// plain text runs at one byte per cycle. A squeezed newline is accepted and
// gives no output. Reset is asynchronous, active low, and needs no clearing
// pass. Either side may stall without losing a beat.
module text_stream_show_and_number_top #(
	parameter int NUMBER_DIGITS = 6
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [tsn_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [tsn_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [7:0]                     s_tdata,   // [7:0] in_byte
	input  logic                           s_tuser,   // [0] file_start
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [7:0]                     m_tdata,   // [7:0] out_byte
	output logic                           m_tlast
);
	import tsn_pkg::*;

	localparam int NW = 4 * NUMBER_DIGITS;
	localparam int QW = NW + $bits(ctrl_t);

	logic          q_full;
	logic          q_not_empty;
	logic          push;
	logic          pop;
	logic [NW-1:0] push_num;
	ctrl_t         push_ctrl;
	logic [QW-1:0] pop_data;
	logic [NW-1:0] pop_num;
	ctrl_t         pop_ctrl;

	assign pop_num  = pop_data[QW-1 -: NW];
	assign pop_ctrl = ctrl_t'(pop_data[$bits(ctrl_t)-1:0]);

	tsn_front #(
		.NUMBER_DIGITS(NUMBER_DIGITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.q_full    (q_full),
		.push      (push),
		.push_num  (push_num),
		.push_ctrl (push_ctrl)
	);

	tsn_queue #(
		.WIDTH(QW)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data ({push_num, push_ctrl}),
		.full      (q_full),
		.pop       (pop),
		.pop_data  (pop_data),
		.not_empty (q_not_empty)
	);

	tsn_back #(
		.NUMBER_DIGITS(NUMBER_DIGITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_not_empty (q_not_empty),
		.q_num       (pop_num),
		.q_ctrl      (pop_ctrl),
		.q_pop       (pop),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tlast     (m_tlast)
	);

endmodule

/* design/tsn_queue.sv */
// Two-entry descriptor queue between the front end and the back end.
// Depends on tsn_pkg and the shared assertion macro header.
`include "text_stream_show_and_number_top_assert.svh"

module tsn_queue #(
	parameter int WIDTH = 36
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] push_data,
	output logic             full,
	input  logic             pop,
	output logic [WIDTH-1:0] pop_data,
	output logic             not_empty
);
	import tsn_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	logic [WIDTH-1:0] slot_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full      = (count_q == CNT_W'(QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign pop_data  = slot_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_data;
		end
	end

	`TSN_ASSERT_IMPLIES(a_push_not_full, push, !full, "descriptor pushed into a full queue")
	`TSN_ASSERT_IMPLIES(a_pop_not_empty, pop, not_empty, "descriptor popped from an empty queue")
	`TSN_ASSERT_NEXT(a_count_up, push && !pop, count_q == CNT_W'($past(count_q) + 1'b1), "queue fill count did not rise on push")

endmodule

/* design/tsn_front.sv */
// Front end: configuration registers, line state and classification of each
// input beat into a descriptor for the back end. Depends on tsn_pkg.
module tsn_front #(
	parameter int NUMBER_DIGITS = 6
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_we,
	input  logic [tsn_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [tsn_pkg::CFG_DATA_W-1:0]  cfg_wdata,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [7:0]                      s_tdata,
	input  logic                            s_tuser,
	input  logic                            q_full,
	output logic                            push,
	output logic [4*NUMBER_DIGITS-1:0]      push_num,
	output tsn_pkg::ctrl_t                  push_ctrl
);
	import tsn_pkg::*;

	localparam int NW = 4 * NUMBER_DIGITS;
	localparam logic [NW-1:0] LINE_ONE = NW'(1);

	// Increment a BCD count; an all-nines count stays where it is.
	function automatic logic [NW-1:0] bcd_bump(input logic [NW-1:0] v);
		logic          carry;
		logic [3:0]    d;
		logic [NW-1:0] r;
		carry = 1'b1;
		r     = v;
		for (int i = 0; i < NUMBER_DIGITS; i++) begin
			d = v[4*i +: 4];
			if (carry) begin
				r[4*i +: 4] = (d == 4'd9) ? 4'd0 : d + 4'd1;
			end
			carry = carry && (d == 4'd9);
		end
		return carry ? v : r;
	endfunction

	logic [1:0]    number_mode_q;
	logic          squeeze_blank_q;
	logic          show_ends_q;
	logic          show_tabs_q;
	logic          show_nonprinting_q;

	logic          prev_nl_q;
	logic [1:0]    blank_run_q;
	logic [NW-1:0] line_q;

	logic          accept;
	logic          eff_prev;
	logic [1:0]    eff_run;
	logic [NW-1:0] eff_line;
	logic          is_nl;
	logic          sq_cond;
	logic [1:0]    run_inc;
	logic          drop;
	logic          num_en;
	logic          tab_hat;
	logic          ctrl_hat;
	logic          del_hat;
	logic          high;
	logic [7:0]    c1;
	logic [7:0]    c2;
	logic [7:0]    c3;
	logic [7:0]    c4;

	assign s_tready = !q_full;
	assign accept   = s_tvalid && s_tready;

	always_comb begin
		eff_prev = s_tuser ? 1'b1 : prev_nl_q;
		eff_run  = s_tuser ? 2'd0 : blank_run_q;
		eff_line = s_tuser ? LINE_ONE : line_q;
		is_nl    = (s_tdata == CH_NL);

		// A newline straight after a newline counts towards the blank run;
		// from the second such newline on, nothing is emitted.
		sq_cond = squeeze_blank_q && is_nl && eff_prev;
		run_inc = (eff_run < 2'd2) ? eff_run + 2'd1 : eff_run;
		drop    = sq_cond && (run_inc > 2'd1);

		num_en = eff_prev && ((number_mode_q == MODE_ALL) ||
			((number_mode_q == MODE_NONBLANK) && !is_nl));

		tab_hat = show_tabs_q && (s_tdata == CH_TAB);
		c1      = tab_hat ? CH_I : s_tdata;

		ctrl_hat = show_nonprinting_q &&
			((c1 < CH_TAB) || ((c1 > CH_NL) && (c1 < CH_PRINT_LO)));
		c2       = ctrl_hat ? c1 + CTRL_OFFSET : c1;
		high     = show_nonprinting_q && (c2 >= CH_HIGH);
		c3       = high ? c2 - CTRL_OFFSET : c2;
		del_hat  = show_nonprinting_q && (c3 == CH_DEL);
		c4       = del_hat ? CH_QMARK : c3;

		push             = accept && !drop;
		push_num         = eff_line;
		push_ctrl.num_en = num_en;
		push_ctrl.dollar = show_ends_q && is_nl;
		push_ctrl.m_dash = high;
		push_ctrl.hat    = tab_hat || ctrl_hat || del_hat;
		push_ctrl.ch     = c4;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			number_mode_q      <= MODE_NONE;
			squeeze_blank_q    <= 1'b0;
			show_ends_q        <= 1'b0;
			show_tabs_q        <= 1'b0;
			show_nonprinting_q <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_NUMBER_MODE:      number_mode_q      <= cfg_wdata;
				REG_SQUEEZE_BLANK:    squeeze_blank_q    <= cfg_wdata[0];
				REG_SHOW_ENDS:        show_ends_q        <= cfg_wdata[0];
				REG_SHOW_TABS:        show_tabs_q        <= cfg_wdata[0];
				REG_SHOW_NONPRINTING: show_nonprinting_q <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_nl_q   <= 1'b1;
			blank_run_q <= 2'd0;
			line_q      <= LINE_ONE;
		end else if (accept) begin
			blank_run_q <= sq_cond ? run_inc : 2'd0;
			// A newline is never rewritten, so the emitted byte is a newline
			// exactly when the input was one.
			prev_nl_q   <= drop ? eff_prev : is_nl;
			line_q      <= (num_en && !drop) ? bcd_bump(eff_line) : eff_line;
		end
	end

endmodule

/* design/tsn_back.sv */
// Back end: expands one descriptor into output bytes behind a registered
// output stage, one beat per cycle unless m_tready stalls it. Depends on tsn_pkg.
module tsn_back #(
	parameter int NUMBER_DIGITS = 6
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       q_not_empty,
	input  logic [4*NUMBER_DIGITS-1:0] q_num,
	input  tsn_pkg::ctrl_t             q_ctrl,
	output logic                       q_pop,
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [7:0]                 m_tdata,
	output logic                       m_tlast
);
	import tsn_pkg::*;

	localparam int NW    = 4 * NUMBER_DIGITS;
	localparam int CNT_W = (NUMBER_DIGITS > 1) ? $clog2(NUMBER_DIGITS) : 1;

	// Lowest phase at or above lo that this descriptor needs.
	function automatic phase_t first_phase(input ctrl_t c, input logic [2:0] lo);
		logic [6:0] en;
		phase_t     r;
		en = {1'b1, c.hat, c.m_dash, c.m_dash, c.dollar, c.num_en, c.num_en};
		r  = PH_CHAR;
		for (int i = 6; i >= 0; i--) begin
			if ((3'(i) >= lo) && en[i]) begin
				r = phase_t'(3'(i));
			end
		end
		return r;
	endfunction

	phase_t        phase_q;
	phase_t        phase_d;
	ctrl_t         cur_q;
	logic [NW-1:0] num_q;
	logic [CNT_W-1:0] cnt_q;
	logic          seen_q;

	logic          m_tvalid_q;
	logic [7:0]    m_tdata_q;
	logic          m_tlast_q;

	logic          out_take;
	logic          step;
	logic          load;
	logic [3:0]    digit;
	logic [7:0]    byte_d;

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;

	assign out_take = !m_tvalid_q || m_tready;
	assign digit    = num_q[NW-1 -: 4];

	always_comb begin
		step    = (phase_q != PH_IDLE) && out_take;
		load    = ((phase_q == PH_IDLE) || (step && (phase_q == PH_CHAR))) && q_not_empty;
		q_pop   = load;
		phase_d = phase_q;
		byte_d  = CH_SPACE;

		case (phase_q)
			PH_NUM: begin
				// Leading zeros show as spaces, but the units digit always prints.
				if ((digit == 4'd0) && !seen_q && (cnt_q != '0)) begin
					byte_d = CH_SPACE;
				end else begin
					byte_d = CH_ZERO + {4'd0, digit};
				end
			end
			PH_TAB:  byte_d = CH_TAB;
			PH_END:  byte_d = CH_DOLLAR;
			PH_M:    byte_d = CH_M;
			PH_DASH: byte_d = CH_DASH;
			PH_HAT:  byte_d = CH_HAT;
			PH_CHAR: byte_d = cur_q.ch;
			default: byte_d = CH_SPACE;
		endcase

		if (step) begin
			case (phase_q)
				PH_NUM: begin
					if (cnt_q == '0) begin
						phase_d = first_phase(cur_q, 3'(PH_TAB));
					end
				end
				PH_CHAR: phase_d = PH_IDLE;
				default: phase_d = first_phase(cur_q, 3'(phase_q) + 3'd1);
			endcase
		end
		if (load) begin
			phase_d = first_phase(q_ctrl, 3'(PH_NUM));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_IDLE;
			m_tvalid_q <= 1'b0;
		end else begin
			phase_q <= phase_d;
			if (step) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			m_tdata_q <= byte_d;
			m_tlast_q <= (phase_q == PH_CHAR);
		end
		if (load) begin
			cur_q  <= q_ctrl;
			num_q  <= q_num;
			cnt_q  <= CNT_W'(NUMBER_DIGITS - 1);
			seen_q <= 1'b0;
		end else if (step && (phase_q == PH_NUM) && (cnt_q != '0)) begin
			num_q  <= num_q << 4;
			cnt_q  <= cnt_q - 1'b1;
			seen_q <= seen_q || (digit != 4'd0);
		end
	end

endmodule
